// ===== rtl/dlls_pkg.sv =====
`default_nettype none

package dlls_pkg;

    // Number of slots in the store.
    localparam int CAPACITY = 16;
    // Bits of a slot address.
    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    // Bits of a link: one more code than there are slots, for the null marker.
    localparam int IDX_W = $clog2(CAPACITY + 1);
    // Bits of the entry count and of the walk counter.
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [IDX_W-1:0] NIL_LINK = IDX_W'(CAPACITY);

    // Request kinds.
    localparam logic [2:0] KIND_INS_FRONT = 3'd0;
    localparam logic [2:0] KIND_INS_BACK  = 3'd1;
    localparam logic [2:0] KIND_REMOVE    = 3'd2;
    localparam logic [2:0] KIND_LIST_FWD  = 3'd3;
    localparam logic [2:0] KIND_LIST_BWD  = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] item_value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic [1:0]         status;
        logic               last;
    } rsp_t;

    // Commands from the sequencer to the three slot memories.
    typedef struct packed {
        logic [SLOT_W-1:0] rd_addr;
        logic              val_we;
        logic [SLOT_W-1:0] val_addr;
        logic [31:0]       val_data;
        logic              nxt_we;
        logic [SLOT_W-1:0] nxt_addr;
        logic [IDX_W-1:0]  nxt_data;
        logic              prv_we;
        logic [SLOT_W-1:0] prv_addr;
        logic [IDX_W-1:0]  prv_data;
    } mem_cmd_t;

    // Registered read data of one slot.
    typedef struct packed {
        logic [31:0]      value;
        logic [IDX_W-1:0] nxt;
        logic [IDX_W-1:0] prv;
    } mem_rd_t;

endpackage

`default_nettype wire

// ===== rtl/doubly_linked_list_store.sv =====
`default_nettype none

// Doubly linked list store: an ordered list of up to CAPACITY signed 32-bit values,
// held as slots with a value, a forward link and a backward link, plus a head and a
// tail. A request either inserts a value at the front or the back (the lowest free
// slot is taken, and an insert into a full store is refused with status full),
// removes the first value equal to the given one searching from the head (status
// done or not found), or lists the values head to tail or tail to head, one result
// item per value with last set on the final one; listing an empty list gives a single
// item with status empty. Kinds 5 to 7 are accepted and dropped without a result.
// Timing: a request is taken only while the sequencer is idle, and the result of the
// previous request may still be waiting in the output register at that time. An
// insert writes the new slot, then patches the link of the old head or tail, then
// gives its result; into an empty list or a full store it goes straight to the result.
// A removal walks the list one slot per cycle, since each step's read address is the
// forward link just read from the slot memories. A listing emits one item per cycle
// while the output is taken. No reset sweep is needed: the slot memories are only
// read through links of slots that are in use.
module doubly_linked_list_store (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire dlls_pkg::req_t req_item,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output dlls_pkg::rsp_t      rsp_item
);

    dlls_pkg::mem_cmd_t mem_cmd;
    dlls_pkg::mem_rd_t  mem_rd;

    // Sequencer: decodes requests, walks the links and drives the output register.
    dlls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item),
        .mem_cmd   (mem_cmd),
        .mem_rd    (mem_rd)
    );

    // The three slot memories share one read address, so a single read returns the
    // value and both links of a slot. Each has its own write port, which lets a
    // removal patch the forward link of its predecessor and the backward link of its
    // successor in the same cycle.
    dlls_ram #(
        .WIDTH (32),
        .DEPTH (dlls_pkg::CAPACITY)
    ) u_value_ram (
        .clk   (clk),
        .we    (mem_cmd.val_we),
        .waddr (mem_cmd.val_addr),
        .wdata (mem_cmd.val_data),
        .raddr (mem_cmd.rd_addr),
        .rdata (mem_rd.value)
    );

    dlls_ram #(
        .WIDTH (dlls_pkg::IDX_W),
        .DEPTH (dlls_pkg::CAPACITY)
    ) u_next_ram (
        .clk   (clk),
        .we    (mem_cmd.nxt_we),
        .waddr (mem_cmd.nxt_addr),
        .wdata (mem_cmd.nxt_data),
        .raddr (mem_cmd.rd_addr),
        .rdata (mem_rd.nxt)
    );

    dlls_ram #(
        .WIDTH (dlls_pkg::IDX_W),
        .DEPTH (dlls_pkg::CAPACITY)
    ) u_prev_ram (
        .clk   (clk),
        .we    (mem_cmd.prv_we),
        .waddr (mem_cmd.prv_addr),
        .wdata (mem_cmd.prv_data),
        .raddr (mem_cmd.rd_addr),
        .rdata (mem_rd.prv)
    );

endmodule

`default_nettype wire

// ===== rtl/dlls_ram.sv =====
`default_nettype none

module dlls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/dlls_ctrl.sv =====
`default_nettype none

module dlls_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire dlls_pkg::req_t    req_item,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output dlls_pkg::rsp_t         rsp_item,
    output dlls_pkg::mem_cmd_t     mem_cmd,
    input  wire dlls_pkg::mem_rd_t mem_rd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LINK = 4'b0010,
        S_WALK = 4'b0100,
        S_RESP = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [2:0]                      kind_reg, kind_next;
    logic [31:0]                     value_reg, value_next;
    logic [dlls_pkg::IDX_W-1:0]      cur_reg, cur_next;
    logic [dlls_pkg::SLOT_W-1:0]     new_reg, new_next;
    logic [dlls_pkg::CNT_W-1:0]      step_reg, step_next;
    logic [1:0]                      status_reg, status_next;
    logic [dlls_pkg::CAPACITY-1:0]   used_reg, used_next;
    logic [dlls_pkg::IDX_W-1:0]      head_reg, head_next;
    logic [dlls_pkg::IDX_W-1:0]      tail_reg, tail_next;
    logic [dlls_pkg::CNT_W-1:0]      count_reg, count_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    dlls_pkg::rsp_t                  rsp_reg, rsp_next;

    logic [dlls_pkg::SLOT_W-1:0]     free_slot;
    logic                            out_free;
    logic                            empty;
    logic                            full;
    logic                            last_step;
    logic [dlls_pkg::IDX_W-1:0]      walk_nxt;
    logic                            walk_fin;

    // A link points at a live entry only if it is in range and that slot is in use.
    function automatic logic slot_ok(
        input logic [dlls_pkg::IDX_W-1:0]    s,
        input logic [dlls_pkg::CAPACITY-1:0] used
    );
        logic ok;
        ok = 1'b0;
        if (s < dlls_pkg::IDX_W'(dlls_pkg::CAPACITY))
        begin
            ok = used[s[dlls_pkg::SLOT_W-1:0]];
        end
        return ok;
    endfunction

    // Lowest free slot.
    always_comb
    begin
        free_slot = '0;
        for (int i = dlls_pkg::CAPACITY - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot = dlls_pkg::SLOT_W'(i);
            end
        end
    end

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == dlls_pkg::CNT_W'(dlls_pkg::CAPACITY));
    assign last_step = (step_reg == dlls_pkg::CNT_W'(dlls_pkg::CAPACITY - 1));
    assign walk_nxt  = (kind_reg == dlls_pkg::KIND_LIST_BWD) ? mem_rd.prv : mem_rd.nxt;
    assign walk_fin  = !slot_ok(walk_nxt, used_reg) || last_step;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        value_next     = value_reg;
        cur_next       = cur_reg;
        new_next       = new_reg;
        step_next      = step_reg;
        status_next    = status_reg;
        used_next      = used_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        mem_cmd         = '0;
        // Holding the read address keeps the current slot on the read port.
        mem_cmd.rd_addr = cur_reg[dlls_pkg::SLOT_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next  = req_item.kind;
                    value_next = req_item.item_value;
                    step_next  = '0;
                    unique case (req_item.kind) inside
                        dlls_pkg::KIND_INS_FRONT, dlls_pkg::KIND_INS_BACK:
                        begin
                            if (full)
                            begin
                                status_next = dlls_pkg::ST_FULL;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                mem_cmd.val_we   = 1'b1;
                                mem_cmd.val_addr = free_slot;
                                mem_cmd.val_data = req_item.item_value;
                                mem_cmd.nxt_we   = 1'b1;
                                mem_cmd.nxt_addr = free_slot;
                                mem_cmd.nxt_data = dlls_pkg::NIL_LINK;
                                mem_cmd.prv_we   = 1'b1;
                                mem_cmd.prv_addr = free_slot;
                                mem_cmd.prv_data = dlls_pkg::NIL_LINK;
                                if (!empty && req_item.kind == dlls_pkg::KIND_INS_FRONT)
                                begin
                                    mem_cmd.nxt_data = head_reg;
                                end
                                if (!empty && req_item.kind == dlls_pkg::KIND_INS_BACK)
                                begin
                                    mem_cmd.prv_data = tail_reg;
                                end
                                used_next[free_slot] = 1'b1;
                                count_next  = count_reg + dlls_pkg::CNT_W'(1);
                                status_next = dlls_pkg::ST_DONE;
                                if (empty)
                                begin
                                    head_next  = dlls_pkg::IDX_W'(free_slot);
                                    tail_next  = dlls_pkg::IDX_W'(free_slot);
                                    state_next = S_RESP;
                                end
                                else
                                begin
                                    new_next   = free_slot;
                                    state_next = S_LINK;
                                end
                            end
                        end
                        dlls_pkg::KIND_REMOVE:
                        begin
                            if (!slot_ok(head_reg, used_reg))
                            begin
                                status_next = dlls_pkg::ST_NOTFOUND;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                mem_cmd.rd_addr = head_reg[dlls_pkg::SLOT_W-1:0];
                                cur_next        = head_reg;
                                state_next      = S_WALK;
                            end
                        end
                        dlls_pkg::KIND_LIST_FWD, dlls_pkg::KIND_LIST_BWD:
                        begin
                            if (req_item.kind == dlls_pkg::KIND_LIST_FWD)
                            begin
                                cur_next = head_reg;
                            end
                            else
                            begin
                                cur_next = tail_reg;
                            end
                            if (!slot_ok(cur_next, used_reg))
                            begin
                                status_next = dlls_pkg::ST_EMPTY;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                mem_cmd.rd_addr = cur_next[dlls_pkg::SLOT_W-1:0];
                                state_next      = S_WALK;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_LINK:
            begin
                if (kind_reg == dlls_pkg::KIND_INS_FRONT)
                begin
                    mem_cmd.prv_we   = 1'b1;
                    mem_cmd.prv_addr = head_reg[dlls_pkg::SLOT_W-1:0];
                    mem_cmd.prv_data = dlls_pkg::IDX_W'(new_reg);
                    head_next        = dlls_pkg::IDX_W'(new_reg);
                end
                else
                begin
                    mem_cmd.nxt_we   = 1'b1;
                    mem_cmd.nxt_addr = tail_reg[dlls_pkg::SLOT_W-1:0];
                    mem_cmd.nxt_data = dlls_pkg::IDX_W'(new_reg);
                    tail_next        = dlls_pkg::IDX_W'(new_reg);
                end
                state_next = S_RESP;
            end

            S_WALK:
            begin
                if (kind_reg == dlls_pkg::KIND_REMOVE)
                begin
                    if (mem_rd.value == value_reg)
                    begin
                        if (slot_ok(mem_rd.prv, used_reg))
                        begin
                            mem_cmd.nxt_we   = 1'b1;
                            mem_cmd.nxt_addr = mem_rd.prv[dlls_pkg::SLOT_W-1:0];
                            mem_cmd.nxt_data = mem_rd.nxt;
                        end
                        else
                        begin
                            head_next = mem_rd.nxt;
                        end
                        if (slot_ok(mem_rd.nxt, used_reg))
                        begin
                            mem_cmd.prv_we   = 1'b1;
                            mem_cmd.prv_addr = mem_rd.nxt[dlls_pkg::SLOT_W-1:0];
                            mem_cmd.prv_data = mem_rd.prv;
                        end
                        else
                        begin
                            tail_next = mem_rd.prv;
                        end
                        used_next[cur_reg[dlls_pkg::SLOT_W-1:0]] = 1'b0;
                        count_next = count_reg - dlls_pkg::CNT_W'(1);
                        if (count_reg == dlls_pkg::CNT_W'(1))
                        begin
                            head_next = dlls_pkg::NIL_LINK;
                            tail_next = dlls_pkg::NIL_LINK;
                        end
                        status_next = dlls_pkg::ST_DONE;
                        state_next  = S_RESP;
                    end
                    else if (last_step || !slot_ok(mem_rd.nxt, used_reg))
                    begin
                        status_next = dlls_pkg::ST_NOTFOUND;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        mem_cmd.rd_addr = mem_rd.nxt[dlls_pkg::SLOT_W-1:0];
                        cur_next        = mem_rd.nxt;
                        step_next       = step_reg + dlls_pkg::CNT_W'(1);
                    end
                end
                else if (out_free)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.out_value = mem_rd.value;
                    rsp_next.status    = dlls_pkg::ST_DONE;
                    rsp_next.last      = walk_fin;
                    if (walk_fin)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mem_cmd.rd_addr = walk_nxt[dlls_pkg::SLOT_W-1:0];
                        cur_next        = walk_nxt;
                        step_next       = step_reg + dlls_pkg::CNT_W'(1);
                    end
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.out_value = '0;
                    rsp_next.status    = status_reg;
                    rsp_next.last      = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= '0;
            step_reg      <= '0;
            status_reg    <= '0;
            used_reg      <= '0;
            head_reg      <= dlls_pkg::NIL_LINK;
            tail_reg      <= dlls_pkg::NIL_LINK;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            step_reg      <= step_next;
            status_reg    <= status_next;
            used_reg      <= used_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        cur_reg   <= cur_next;
        new_reg   <= new_next;
        rsp_reg   <= rsp_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

    // The used bits and the entry count describe the same set of slots.
    a_count_matches_used: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_reg) == 32'(count_reg))
        else $error("entry count differs from the number of used slots");

    // The head is null exactly when the list is empty.
    a_head_null_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == (head_reg == dlls_pkg::NIL_LINK))
        else $error("head and entry count disagree on emptiness");

    // A walk only ever sits on a live slot.
    a_walk_on_live_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> slot_ok(cur_reg, used_reg))
        else $error("walk reached a slot that is not in use");

    // An insert that is not refused adds exactly one entry.
    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && req_valid && !full
         && (req_item.kind == dlls_pkg::KIND_INS_FRONT
             || req_item.kind == dlls_pkg::KIND_INS_BACK))
        |=> count_reg == $past(count_reg) + dlls_pkg::CNT_W'(1))
        else $error("insert did not add one entry");

endmodule

`default_nettype wire

// ===== bench/doubly_linked_list_store_tb.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the doubly linked list store.
module doubly_linked_list_store_tb;

    import dlls_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 12;
    // The receiver holds off for this many cycles once, so that the store backs up.
    localparam int HOLD_CYCLES  = 400;
    // The worst request walks CAPACITY slots, so the quiet stretch at the end is scaled by CAPACITY.
    localparam int DRAIN_CYCLES = 4 * CAPACITY;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int MAX_REPORTS  = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req_item = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp_item;

    // Items still to be offered, and result items still to arrive, oldest first.
    req_t pending_req_q[$];
    rsp_t expected_rsp_q[$];

    // The bench's own picture of the list contents, head first.
    logic signed [31:0] deque_contents[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_request = 1'b0;
    logic hold_started = 1'b0;
    int hold_left = 0;
    int fail_count = 0;
    int cycle_count = 0;

    doubly_linked_list_store dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Works out the result items that one accepted request causes, and updates the
    // bench's copy of the list in the same way as the store must.
    task automatic predict_list_request(input req_t r);
        rsp_t res;
        int idx;
        int hit;
        begin
            res = '0;
            res.last = 1'b1;
            case (r.kind)
                KIND_INS_FRONT, KIND_INS_BACK:
                begin
                    // A full store refuses the insert and leaves the list alone.
                    if (deque_contents.size() >= CAPACITY)
                        res.status = ST_FULL;
                    else
                    begin
                        res.status = ST_DONE;
                        if (r.kind == KIND_INS_FRONT)
                            deque_contents.push_front(r.item_value);
                        else
                            deque_contents.push_back(r.item_value);
                    end
                    expected_rsp_q.push_back(res);
                end
                KIND_REMOVE:
                begin
                    // Only the first match, counting from the head, is taken out.
                    hit = -1;
                    for (idx = 0; idx < deque_contents.size() && hit < 0; idx++)
                        if (deque_contents[idx] == r.item_value)
                            hit = idx;
                    if (hit >= 0)
                    begin
                        deque_contents.delete(hit);
                        res.status = ST_DONE;
                    end
                    else
                        res.status = ST_NOTFOUND;
                    expected_rsp_q.push_back(res);
                end
                KIND_LIST_FWD, KIND_LIST_BWD:
                begin
                    if (deque_contents.size() == 0)
                    begin
                        res.status = ST_EMPTY;
                        expected_rsp_q.push_back(res);
                    end
                    else
                    begin
                        for (idx = 0; idx < deque_contents.size(); idx++)
                        begin
                            res.status = ST_DONE;
                            res.last = (idx == deque_contents.size() - 1);
                            if (r.kind == KIND_LIST_FWD)
                                res.out_value = deque_contents[idx];
                            else
                                res.out_value = deque_contents[deque_contents.size() - 1 - idx];
                            expected_rsp_q.push_back(res);
                        end
                    end
                end
                default:
                begin
                    // Unused kinds are dropped by the store without a result item.
                end
            endcase
        end
    endtask

    task automatic note_failure(input string what, input rsp_t exp_rsp, input rsp_t got_rsp);
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display({"%0t: %s: expected value %0d status %0d last %0d,",
                          " got value %0d status %0d last %0d"},
                         $realtime, what, exp_rsp.out_value, exp_rsp.status, exp_rsp.last,
                         got_rsp.out_value, got_rsp.status, got_rsp.last);
        end
    endtask

    // Driver: an accepted item is passed to the predictor; the next item from the
    // queue is put up straight away or after a random gap. Once raised, valid and the
    // payload stay put until the handshake.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                predict_list_request(req_item);
                if (pending_req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    req_item <= pending_req_q.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
            else if (!req_valid && pending_req_q.size() != 0 &&
                     $urandom_range(0, 99) >= send_idle_pct)
            begin
                req_item <= pending_req_q.pop_front();
                req_valid <= 1'b1;
            end
        end
    end

    // Monitor: every accepted result item is compared with the oldest expectation.
    // Ready is dropped at random, and once for a long stretch when asked to.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp_q.size() == 0)
                    note_failure("unexpected result item", '0, rsp_item);
                else if (rsp_item.out_value !== expected_rsp_q[0].out_value ||
                         rsp_item.status !== expected_rsp_q[0].status ||
                         rsp_item.last !== expected_rsp_q[0].last)
                    note_failure("result item mismatch", expected_rsp_q.pop_front(), rsp_item);
                else
                    void'(expected_rsp_q.pop_front());
            end
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                rsp_ready <= 1'b0;
            end
            else if (hold_request && !hold_started)
            begin
                hold_started <= 1'b1;
                hold_left <= HOLD_CYCLES;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Guard against a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic req_t make_req(input logic [2:0] k, input logic signed [31:0] v);
        req_t r;
        begin
            r.kind = k;
            r.item_value = v;
            return r;
        end
    endfunction

    // Mostly small values so that removals find matches, with full-width random
    // values and the two extremes mixed in.
    function automatic logic signed [31:0] pick_value();
        int sel;
        begin
            sel = $urandom_range(0, 9);
            if (sel < 5)
                return $signed($urandom_range(0, 11)) - 6;
            else if (sel < 8)
                return $urandom;
            else if (sel == 8)
                return 32'sh8000_0000;
            else
                return 32'sh7fff_ffff;
        end
    endfunction

    // Queues a run of random requests, weighted towards inserts, removals or listings.
    // Unused kinds are sprinkled in as noise and are not counted.
    task automatic queue_random_requests(input int count, input int ins_w, input int rem_w,
                                         input int lst_w);
        int done_cnt;
        int roll;
        logic [2:0] k;
        begin
            done_cnt = 0;
            while (done_cnt < count)
            begin
                roll = $urandom_range(0, ins_w + rem_w + lst_w + 2);
                if (roll < ins_w)
                    k = ($urandom_range(0, 1) != 0) ? KIND_INS_BACK : KIND_INS_FRONT;
                else if (roll < ins_w + rem_w)
                    k = KIND_REMOVE;
                else if (roll < ins_w + rem_w + lst_w)
                    k = ($urandom_range(0, 1) != 0) ? KIND_LIST_BWD : KIND_LIST_FWD;
                else
                    k = 3'($urandom_range(5, 7));
                pending_req_q.push_back(make_req(k, pick_value()));
                if (k <= KIND_LIST_BWD)
                    done_cnt++;
            end
        end
    endtask

    task automatic wait_queue_drained();
        begin
            while (pending_req_q.size() != 0)
                @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        logic signed [31:0] fill_vals[CAPACITY];
        int i;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty-list cases, the value extremes, a duplicate so that the
        // first match from the head is the one removed, removal at head, middle and
        // tail, the unused kinds, and finally emptying the list again.
        pending_req_q.push_back(make_req(KIND_LIST_FWD, 32'sd0));
        pending_req_q.push_back(make_req(KIND_LIST_BWD, -32'sd1));
        pending_req_q.push_back(make_req(KIND_REMOVE, 32'sd7));
        pending_req_q.push_back(make_req(KIND_INS_FRONT, 32'sh8000_0000));
        pending_req_q.push_back(make_req(KIND_INS_BACK, 32'sh7fff_ffff));
        pending_req_q.push_back(make_req(KIND_INS_FRONT, 32'sd0));
        pending_req_q.push_back(make_req(KIND_INS_BACK, -32'sd1));
        pending_req_q.push_back(make_req(KIND_INS_FRONT, 32'sd5));
        pending_req_q.push_back(make_req(KIND_INS_BACK, 32'sd5));
        pending_req_q.push_back(make_req(KIND_LIST_FWD, 32'sh5555_5555));
        pending_req_q.push_back(make_req(KIND_LIST_BWD, 32'shaaaa_aaaa));
        pending_req_q.push_back(make_req(KIND_REMOVE, 32'sd5));
        pending_req_q.push_back(make_req(KIND_REMOVE, 32'sd1234));
        pending_req_q.push_back(make_req(KIND_REMOVE, -32'sd1));
        pending_req_q.push_back(make_req(KIND_REMOVE, 32'sd0));
        pending_req_q.push_back(make_req(3'd5, 32'sd0));
        pending_req_q.push_back(make_req(3'd6, 32'sh8000_0000));
        pending_req_q.push_back(make_req(3'd7, 32'sh7fff_ffff));
        pending_req_q.push_back(make_req(KIND_LIST_FWD, 32'sd0));
        pending_req_q.push_back(make_req(KIND_REMOVE, 32'sh8000_0000));
        pending_req_q.push_back(make_req(KIND_REMOVE, 32'sh7fff_ffff));
        pending_req_q.push_back(make_req(KIND_REMOVE, 32'sd5));
        pending_req_q.push_back(make_req(KIND_LIST_BWD, 32'sd0));
        wait_queue_drained();

        // Back-pressure: the receiver stops for a long stretch while the sender fills
        // the now empty store to the brim, overflows it at both ends, lists it both
        // ways and takes a few values out again. The store has to stall its input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge clk);
        hold_request <= 1'b1;
        for (i = 0; i < CAPACITY; i++)
        begin
            fill_vals[i] = pick_value();
            pending_req_q.push_back(make_req((i % 3 == 0) ? KIND_INS_FRONT : KIND_INS_BACK,
                                             fill_vals[i]));
        end
        pending_req_q.push_back(make_req(KIND_INS_BACK, pick_value()));
        pending_req_q.push_back(make_req(KIND_INS_FRONT, pick_value()));
        pending_req_q.push_back(make_req(KIND_LIST_FWD, 32'sd0));
        pending_req_q.push_back(make_req(KIND_LIST_BWD, 32'sd0));
        pending_req_q.push_back(make_req(KIND_REMOVE, fill_vals[CAPACITY - 1]));
        pending_req_q.push_back(make_req(KIND_REMOVE, fill_vals[2]));
        pending_req_q.push_back(make_req(KIND_INS_FRONT, pick_value()));
        pending_req_q.push_back(make_req(KIND_LIST_FWD, 32'sd0));
        wait_queue_drained();

        // Random part in three phases with different idling on each side, and with the
        // mix of requests shifting so that the list both fills up and drains away.
        send_idle_pct = 19;
        recv_idle_pct = 73;
        queue_random_requests(35, 6, 3, 1);
        wait_queue_drained();

        send_idle_pct = 73;
        recv_idle_pct = 19;
        queue_random_requests(35, 3, 6, 1);
        wait_queue_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_requests(30, 5, 4, 2);
        wait_queue_drained();

        // Let the last item be taken and every expected result item come back.
        while (req_valid || expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        fail_count += expected_rsp_q.size();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dlls_pkg.sv
rtl/dlls_ram.sv
rtl/dlls_ctrl.sv
rtl/doubly_linked_list_store.sv
bench/doubly_linked_list_store_tb.sv
